[rtl/assert_macros.svh]
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mhcf_pkg.sv]
// Shared types, constants and the CRC-32 byte fold for the header framer.
// No dependencies.
package mhcf_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned VERSION_W  = 16;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned HDR_BYTES  = 8;
  localparam int unsigned HDR_W      = HDR_BYTES * BYTE_W;
  localparam int unsigned HDR_IDX_W  = $clog2(HDR_BYTES);
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // Register index, taken from paddr[2]
  localparam logic REG_VERSION = 1'b0;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = HDR_IDX_W'(HDR_BYTES - 1);

  // Load request from the CRC stage to the header serializer
  typedef struct packed {
    logic             vld;
    logic [HDR_W-1:0] data;
  } hdr_load_t;

  // Fold one byte into a reflected CRC-32, bit by bit (pure XOR network)
  function automatic logic [CRC_W-1:0] crc_fold_byte(input logic [CRC_W-1:0] crc,
                                                     input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mhcf_if.sv]
// Stream interfaces for body words in and header words out.
// Depends on mhcf_pkg for field widths.
interface mhcf_body_if import mhcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] body_byte;
  logic              body_last;

  modport source (output valid, output body_byte, output body_last, input ready);
  modport sink   (input valid, input body_byte, input body_last, output ready);
endinterface

interface mhcf_hdr_if import mhcf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] header_byte;
  logic              header_last;

  modport source (output valid, output header_byte, output header_last, input ready);
  modport sink   (input valid, input header_byte, input header_last, output ready);
endinterface

[rtl/mhcf_hdr_tx.sv]
// Header serializer: holds one 8-byte header and sends it low byte first.
// Depends on mhcf_pkg and the mhcf_hdr_if interface.
module mhcf_hdr_tx import mhcf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  hdr_load_t  load,
  output logic       free,
  mhcf_hdr_if.source out_hdr
);

  logic [HDR_W-1:0]     shift_r, shift_nxt;
  logic [HDR_IDX_W-1:0] idx_r, idx_nxt;
  logic                 vld_r, vld_nxt;
  logic                 fire;
  logic                 at_last;

  assign fire    = vld_r && out_hdr.ready;
  assign at_last = (idx_r == HDR_LAST_IDX);
  // free this cycle if empty or the final word is leaving now
  assign free    = !vld_r || (fire && at_last);

  assign out_hdr.valid       = vld_r;
  assign out_hdr.header_byte = shift_r[BYTE_W-1:0];
  assign out_hdr.header_last = at_last;

  // next-state: load a new header, or step to the next word
  always_comb begin
    shift_nxt = shift_r;
    idx_nxt   = idx_r;
    vld_nxt   = vld_r;
    priority if (load.vld) begin
      shift_nxt = load.data;
      idx_nxt   = '0;
      vld_nxt   = 1'b1;
    end else if (fire) begin
      shift_nxt = shift_r >> BYTE_W;
      idx_nxt   = idx_r + HDR_IDX_W'(1);
      vld_nxt   = !at_last;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

endmodule

[rtl/message_header_crc32_framer.sv]
// Message header framer. Body words enter one per cycle unless a last word
// is held back; every word is folded into a reflected CRC-32 (poly 0xEDB88320,
// init all ones) and counted mod 65536. After the word flagged last, an 8-word
// header follows on the output: version low/high, length low/high, then the
// complemented CRC low byte first. Throughput is one body word per clock while
// no last word waits: the CRC fold is one registered stage. A last word waits in
// the input register only while the previous header is still being sent.
// Version register at byte address 0 of the APB port.
// Depends on mhcf_pkg, mhcf_if, mhcf_hdr_tx and assert_macros.svh.
`include "assert_macros.svh"

module message_header_crc32_framer import mhcf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mhcf_body_if.sink             in_body,
  mhcf_hdr_if.source            out_hdr,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [VERSION_W-1:0] version_r;
  logic [BYTE_W-1:0]    in_byte_r;
  logic                 in_last_r;
  logic                 in_vld_r, in_vld_nxt;
  logic [CRC_W-1:0]     crc_r, crc_nxt, crc_fold;
  logic [COUNT_W-1:0]   cnt_r, cnt_nxt, cnt_inc;
  logic                 hdr_free;
  logic                 adv;
  logic                 in_fire;
  hdr_load_t            hdr_load;

  // APB register port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_VERSION) ?
                      {{(APB_DATA_W-VERSION_W){1'b0}}, version_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_VERSION) begin
      version_r <= cfg_pwdata[VERSION_W-1:0];
    end
  end

  // input register advance: a last word needs the serializer free
  assign adv           = in_vld_r && (!in_last_r || hdr_free);
  assign in_body.ready = !in_vld_r || adv;
  assign in_fire       = in_body.valid && in_body.ready;
  assign in_vld_nxt    = in_fire || (in_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_body.body_byte;
      in_last_r <= in_body.body_last;
    end
    if (!rst_n) in_vld_r <= 1'b0;
    else        in_vld_r <= in_vld_nxt;
  end

  // CRC fold and length count; re-arm after a last word
  assign crc_fold = crc_fold_byte(crc_r, in_byte_r);
  assign cnt_inc  = cnt_r + COUNT_W'(1);

  always_comb begin
    crc_nxt = crc_r;
    cnt_nxt = cnt_r;
    if (adv) begin
      crc_nxt = in_last_r ? CRC_INIT : crc_fold;
      cnt_nxt = in_last_r ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
      cnt_r <= '0;
    end else begin
      crc_r <= crc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // header image, first word in the low byte
  assign hdr_load.vld  = adv && in_last_r;
  assign hdr_load.data = {~crc_fold, cnt_inc, version_r};

  mhcf_hdr_tx u_hdr_tx (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (hdr_load),
    .free    (hdr_free),
    .out_hdr (out_hdr)
  );

  // checks
  `ASSERT_NEXT(a_rearm, clk, rst_n, hdr_load.vld, (crc_r == CRC_INIT) && (cnt_r == '0))
  `ASSERT_IMPL(a_load_free, clk, rst_n, hdr_load.vld, hdr_free)
  `ASSERT_NEXT(a_hdr_done, clk, rst_n,
               out_hdr.valid && out_hdr.ready && out_hdr.header_last && !hdr_load.vld,
               !out_hdr.valid)

endmodule
